[rtl/utf8_stream_decoder_macros.svh]
// assertion macros shared by the decoder's checker
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

// checked only outside reset
`define USD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define USD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/usd_pkg.sv]
// types, constants and defaults of the utf-8 stream decoder
package usd_pkg;

   localparam int USD_FIFO_DEPTH = 4;

   localparam logic [7:0]  ASCII_MAX  = 8'h7F;
   localparam logic [7:0]  CONT_MAX   = 8'hBF;
   localparam logic [7:0]  LEAD2_MAX  = 8'hDF;
   localparam logic [7:0]  LEAD3_MAX  = 8'hEF;
   localparam logic [7:0]  LEAD4_MAX  = 8'hF7;
   localparam logic [7:0]  CONT_MASK  = 8'h3F;
   localparam logic [7:0]  LEAD2_MASK = 8'h1F;
   localparam logic [7:0]  LEAD3_MASK = 8'h0F;
   localparam logic [7:0]  LEAD4_MASK = 8'h07;
   localparam logic [20:0] REPL_CP    = 21'h00003F;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_string;
   } req_type;

   typedef struct packed {
      logic [20:0] code_point;
      logic        last_of_run;
   } rsp_type;

   // decode outcome of one byte: results to queue and the next state
   typedef struct packed {
      logic [1:0]  num;
      rsp_type     first;
      rsp_type     second;
      logic [1:0]  pend;
      logic [20:0] acc;
   } dec_type;

endpackage

[rtl/usd_decode.sv]
// byte classifier and accumulator update for one utf-8 byte
module usd_decode (
   input  usd_pkg::req_type item,
   input  logic [1:0]       pend_count,
   input  logic [20:0]      acc_value,
   output usd_pkg::dec_type dec
);
   import usd_pkg::*;

   logic [20:0] acc_shift;
   logic [7:0]  cont_bits;

   assign cont_bits = item.data_byte & CONT_MASK;
   assign acc_shift = {acc_value[14:0], cont_bits[5:0]};

   always_comb begin
      dec.num                = 2'd0;
      dec.first.code_point   = REPL_CP;
      dec.first.last_of_run  = 1'b0;
      dec.second.code_point  = REPL_CP;
      dec.second.last_of_run = 1'b1;
      dec.pend               = pend_count;
      dec.acc                = acc_value;

      if (item.data_byte inside {[8'h00:ASCII_MAX]}) begin
         // ascii interrupting a sequence gets a '?' in front
         if (pend_count != 2'd0) begin
            dec.second.code_point = {13'd0, item.data_byte};
            dec.num               = 2'd2;
            dec.pend              = 2'd0;
         end else begin
            dec.first.code_point = {13'd0, item.data_byte};
            dec.num              = 2'd1;
         end
      end else if (item.data_byte inside {[8'h80:CONT_MAX]}) begin
         if (pend_count != 2'd0) begin
            dec.acc  = acc_shift;
            dec.pend = pend_count - 2'd1;
            if (pend_count == 2'd1) begin
               dec.first.code_point = acc_shift;
               dec.num              = 2'd1;
            end
         end else begin
            dec.num = 2'd1;
         end
      end else if (item.data_byte inside {[8'hC0:LEAD2_MAX]}) begin
         dec.acc  = {13'd0, item.data_byte & LEAD2_MASK};
         dec.pend = 2'd1;
      end else if (item.data_byte inside {[8'hE0:LEAD3_MAX]}) begin
         dec.acc  = {13'd0, item.data_byte & LEAD3_MASK};
         dec.pend = 2'd2;
      end else if (item.data_byte inside {[8'hF0:LEAD4_MAX]}) begin
         dec.acc  = {13'd0, item.data_byte & LEAD4_MASK};
         dec.pend = 2'd3;
      end else begin
         dec.num  = 2'd1;
         dec.pend = 2'd0;
      end

      if (item.end_of_string) begin
         // unfinished sequence at end of string
         if (dec.pend != 2'd0) begin
            if (dec.num == 2'd0) begin
               dec.num = 2'd1;
            end else begin
               dec.num = 2'd2;
            end
         end
         dec.pend = 2'd0;
         dec.acc  = 21'd0;
      end

      dec.first.last_of_run = (dec.num == 2'd1);
   end

endmodule

[rtl/usd_result_fifo.sv]
// small result queue taking up to two items per cycle, giving one
module usd_result_fifo #(
   parameter int FifoDepth = usd_pkg::USD_FIFO_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       push_num,
   input  usd_pkg::rsp_type push_first,
   input  usd_pkg::rsp_type push_second,
   output logic             has_room,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output usd_pkg::rsp_type rsp_payload
);
   import usd_pkg::*;

   localparam int PtrWidth = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
   localparam int CntWidth = $clog2(FifoDepth + 1);

   rsp_type               slot_ff [FifoDepth];
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   wr_ptr_plus1, wr_ptr_plus2, rd_ptr_plus1;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  pop;

   assign wr_ptr_plus1 = (wr_ptr_ff == PtrWidth'(FifoDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign wr_ptr_plus2 = (wr_ptr_plus1 == PtrWidth'(FifoDepth - 1)) ? '0
                                                                     : wr_ptr_plus1 + 1'b1;
   assign rd_ptr_plus1 = (rd_ptr_ff == PtrWidth'(FifoDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;

   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = slot_ff[rd_ptr_ff];
   assign pop         = rsp_valid && rsp_ready;
   assign has_room    = (count_ff <= CntWidth'(FifoDepth - 2));

   always_comb begin
      rd_ptr_in = pop ? rd_ptr_plus1 : rd_ptr_ff;
      case (push_num)
         2'd1:    wr_ptr_in = wr_ptr_plus1;
         2'd2:    wr_ptr_in = wr_ptr_plus2;
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      count_in = count_ff + CntWidth'(push_num) - CntWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_num != 2'd0) begin
         slot_ff[wr_ptr_ff] <= push_first;
      end
      if (push_num == 2'd2) begin
         slot_ff[wr_ptr_plus1] <= push_second;
      end
   end

endmodule

[rtl/utf8_stream_decoder.sv]
// top level of the streaming utf-8 to code point decoder
//
//   channel  dir  payload                          handshake
//   req_     in   data_byte[8], end_of_string[1]   req_valid / req_ready
//   rsp_     out  code_point[21], last_of_run[1]   rsp_valid / rsp_ready
//
// one byte accepted per cycle while the queue has room; a byte taken is held in the
// input register, then its results go into the result queue, from which they
// leave on rsp_
// a byte giving two results needs the output port twice, so a long run of them
// is limited by the single output port
// reset (synchronous) empties the input register and queue, clears state
// req_ready drops only while the held byte waits for two free queue slots
module utf8_stream_decoder #(
   parameter int FifoDepth = usd_pkg::USD_FIFO_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  usd_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output usd_pkg::rsp_type rsp_payload
);
   import usd_pkg::*;

   // input register
   req_type     item_ff;
   logic        item_valid_ff, item_valid_in;

   // decoder state
   logic [1:0]  pend_ff, pend_in;
   logic [20:0] acc_ff, acc_in;

   dec_type     dec;
   logic        has_room;
   logic        advance;
   logic [1:0]  push_num;

   usd_decode u_decode (
      .item       (item_ff),
      .pend_count (pend_ff),
      .acc_value  (acc_ff),
      .dec        (dec)
   );

   // held byte moves on once the queue can take both of its possible results
   assign advance   = item_valid_ff && has_room;
   assign req_ready = !item_valid_ff || advance;
   assign push_num  = advance ? dec.num : 2'd0;

   always_comb begin
      item_valid_in = item_valid_ff;
      pend_in       = pend_ff;
      acc_in        = acc_ff;
      if (advance) begin
         item_valid_in = 1'b0;
         pend_in       = dec.pend;
         acc_in        = dec.acc;
      end
      if (req_valid && req_ready) begin
         item_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         pend_ff       <= 2'd0;
         acc_ff        <= 21'd0;
      end else begin
         item_valid_ff <= item_valid_in;
         pend_ff       <= pend_in;
         acc_ff        <= acc_in;
      end
   end

   // payload register, no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_payload;
      end
   end

   usd_result_fifo #(
      .FifoDepth (FifoDepth)
   ) u_result_fifo (
      .clock       (clock),
      .reset       (reset),
      .push_num    (push_num),
      .push_first  (dec.first),
      .push_second (dec.second),
      .has_room    (has_room),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

[rtl/usd_checker.sv]
// port-level checker for the utf-8 stream decoder, bound to the top level
`include "utf8_stream_decoder_macros.svh"

module usd_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input usd_pkg::rsp_type rsp_payload
);
   import usd_pkg::*;

   `USD_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "rsp_valid dropped under stall")
   `USD_ASSERT(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_payload), "rsp item changed under stall")
   `USD_ASSERT(a_pair_follows, rsp_valid && rsp_ready && !rsp_payload.last_of_run |=> rsp_valid, "second result of a byte missing")
   `USD_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid && req_ready, "not empty after reset")

endmodule

bind utf8_stream_decoder usd_checker u_checker (.*);

[tb/utf8_stream_decoder_tb.sv]
// self-checking testbench of the streaming utf-8 to code point decoder
module utf8_stream_decoder_tb;
   import usd_pkg::*;

   // watchdog limit: cycles in a row with no item moving on either side
   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 1250;
   localparam int DRAIN_EVERY  = 400;
   // results pass only the input register and the result queue, so a short tail suffices
   localparam int TAIL_CYCLES  = 8;

   // one row of the directed table; typed rows carry their results by hand
   typedef struct packed {
      logic [7:0]  data_byte;
      logic        end_of_string;
      logic        typed;
      logic [1:0]  count;
      logic [20:0] cp_first;
      logic [20:0] cp_second;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   // decoder model state
   logic [1:0]  cont_due = 2'd0;
   logic [20:0] partial_cp = 21'd0;

   rsp_type expected_cps[$];
   req_type string_bytes[$];

   // hand-typed expectation of the byte now on offer
   logic        cur_typed = 1'b0;
   logic [1:0]  cur_count = 2'd0;
   logic [20:0] cur_cp_first = 21'd0;
   logic [20:0] cur_cp_second = 21'd0;

   // no idling on either side while set
   logic steady = 1'b0;

   int errors = 0;
   int items_sent = 0;
   int strings_sent = 0;
   int cps_checked = 0;
   int double_items = 0;
   int stall_cycles = 0;

   // directed table: ascii and byte-range extremes, stray continuation bytes,
   // invalid bytes, every sequence length up to the largest code point, ascii
   // breaking into a sequence, a lead restarting one, a fault dropping one,
   // and sequences left open at the end of a string
   stim_row_type directed_rows [25] = '{
      '{8'h00, 1'b0, 1'b1, 2'd1, 21'h000000, 21'h0},
      '{8'h7F, 1'b0, 1'b1, 2'd1, 21'h00007F, 21'h0},
      '{8'h80, 1'b0, 1'b1, 2'd1, REPL_CP,    21'h0},
      '{8'hBF, 1'b0, 1'b1, 2'd1, REPL_CP,    21'h0},
      '{8'hF8, 1'b0, 1'b1, 2'd1, REPL_CP,    21'h0},
      '{8'hFF, 1'b1, 1'b1, 2'd1, REPL_CP,    21'h0},
      '{8'hC2, 1'b0, 1'b1, 2'd0, 21'h0,      21'h0},
      '{8'hA9, 1'b0, 1'b0, 2'd0, 21'h0,      21'h0},
      '{8'hE2, 1'b0, 1'b0, 2'd0, 21'h0,      21'h0},
      '{8'h82, 1'b0, 1'b0, 2'd0, 21'h0,      21'h0},
      '{8'hAC, 1'b0, 1'b0, 2'd0, 21'h0,      21'h0},
      '{8'hF7, 1'b0, 1'b0, 2'd0, 21'h0,      21'h0},
      '{8'hBF, 1'b0, 1'b0, 2'd0, 21'h0,      21'h0},
      '{8'hBF, 1'b0, 1'b0, 2'd0, 21'h0,      21'h0},
      '{8'hBF, 1'b0, 1'b0, 2'd0, 21'h0,      21'h0},
      '{8'hC3, 1'b0, 1'b1, 2'd0, 21'h0,      21'h0},
      '{8'h41, 1'b0, 1'b1, 2'd2, REPL_CP,    21'h000041},
      '{8'hE0, 1'b0, 1'b0, 2'd0, 21'h0,      21'h0},
      '{8'hC5, 1'b0, 1'b0, 2'd0, 21'h0,      21'h0},
      '{8'h80, 1'b0, 1'b0, 2'd0, 21'h0,      21'h0},
      '{8'hF0, 1'b0, 1'b0, 2'd0, 21'h0,      21'h0},
      '{8'hFF, 1'b0, 1'b1, 2'd1, REPL_CP,    21'h0},
      '{8'hE1, 1'b0, 1'b0, 2'd0, 21'h0,      21'h0},
      '{8'h80, 1'b1, 1'b0, 2'd0, 21'h0,      21'h0},
      '{8'hF3, 1'b1, 1'b1, 2'd1, REPL_CP,    21'h0}
   };

   utf8_stream_decoder u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   // decode one byte against the model state; returns how many code points it
   // gives, in order in cp_a then cp_b
   function automatic int decode_byte(input logic [7:0] b, input logic eos,
                                      output logic [20:0] cp_a,
                                      output logic [20:0] cp_b);
      logic [20:0] got [2];
      int n;
      n = 0;
      got[0] = '0;
      got[1] = '0;
      if (b <= ASCII_MAX) begin
         // ascii inside a sequence: replacement first, then the character
         if (cont_due != 2'd0) begin
            got[n] = REPL_CP;
            n++;
            cont_due = 2'd0;
         end
         got[n] = 21'(b);
         n++;
      end else if (b <= CONT_MAX) begin
         if (cont_due != 2'd0) begin
            partial_cp = {partial_cp[14:0], 6'(b & CONT_MASK)};
            cont_due = cont_due - 2'd1;
            if (cont_due == 2'd0) begin
               got[n] = partial_cp;
               n++;
            end
         end else begin
            // stray continuation
            got[n] = REPL_CP;
            n++;
         end
      end else if (b <= LEAD2_MAX) begin
         cont_due = 2'd1;
         partial_cp = 21'(b & LEAD2_MASK);
      end else if (b <= LEAD3_MAX) begin
         cont_due = 2'd2;
         partial_cp = 21'(b & LEAD3_MASK);
      end else if (b <= LEAD4_MAX) begin
         cont_due = 2'd3;
         partial_cp = 21'(b & LEAD4_MASK);
      end else begin
         got[n] = REPL_CP;
         n++;
         cont_due = 2'd0;
      end
      // sequence left open by the last byte of the string
      if (eos) begin
         if (cont_due != 2'd0) begin
            got[n] = REPL_CP;
            n++;
         end
         cont_due = 2'd0;
         partial_cp = '0;
      end
      cp_a = got[0];
      cp_b = got[1];
      return n;
   endfunction

   // predict on every byte taken, check every code point delivered
   always @(posedge clock) begin : monitor
      int n;
      logic [20:0] cp_a;
      logic [20:0] cp_b;
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            n = decode_byte(req_payload.data_byte, req_payload.end_of_string, cp_a, cp_b);
            // typed rows override the model's results but not its state update
            if (cur_typed) begin
               n = cur_count;
               cp_a = cur_cp_first;
               cp_b = cur_cp_second;
            end
            if (n == 2)
               double_items++;
            if (n >= 1)
               expected_cps.insert(expected_cps.size(),
                                   rsp_type'{code_point: cp_a, last_of_run: (n == 1)});
            if (n == 2)
               expected_cps.insert(expected_cps.size(),
                                   rsp_type'{code_point: cp_b, last_of_run: 1'b1});
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_cps.size() == 0) begin
               $error("unexpected result: code_point %h last_of_run %b",
                      rsp_payload.code_point, rsp_payload.last_of_run);
               errors++;
            end else begin
               want = expected_cps.pop_front();
               cps_checked++;
               if (rsp_payload.code_point !== want.code_point) begin
                  $error("code_point: expected %h, actual %h",
                         want.code_point, rsp_payload.code_point);
                  errors++;
               end
               if (rsp_payload.last_of_run !== want.last_of_run) begin
                  $error("last_of_run: expected %b, actual %b",
                         want.last_of_run, rsp_payload.last_of_run);
                  errors++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
   end

   // receiver: back-pressure in about 8 percent of cycles, none while steady
   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= 8);
   end

   // watchdog
   initial begin
      while (stall_cycles < STALL_LIMIT)
         @(posedge clock);
      $display("FAIL utf8_stream_decoder");
      $finish;
   end

   // offer one byte from a falling edge and hold it until taken
   task automatic send_item(input logic [7:0] b, input logic eos);
      while (!steady && $urandom_range(0, 99) < 8) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{data_byte: b, end_of_string: eos};
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
      items_sent++;
      if (eos)
         strings_sent++;
   endtask

   // hold the sender off until every pending code point has come out
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (expected_cps.size() != 0)
         @(negedge clock);
   endtask

   // append one byte, not yet the last of its string
   task automatic add_byte(input logic [7:0] b);
      string_bytes.insert(string_bytes.size(),
                          req_type'{data_byte: b, end_of_string: 1'b0});
   endtask

   // build one string: mostly well-formed characters of every length with
   // random payload, some stray, invalid, cut-short and random bytes
   task automatic build_string();
      int n_chars;
      int kind;
      int len;
      int keep;
      logic [20:0] cp;
      logic [7:0] lead;
      n_chars = $urandom_range(1, 10);
      for (int i = 0; i < n_chars; i++) begin
         kind = $urandom_range(0, 99);
         cp = 21'($urandom);
         if (kind < 30) begin
            add_byte(8'($urandom_range(0, 127)));
         end else if (kind < 50) begin
            add_byte(8'hC0 | 8'(cp[10:6]));
            add_byte(8'h80 | 8'(cp[5:0]));
         end else if (kind < 68) begin
            add_byte(8'hE0 | 8'(cp[15:12]));
            add_byte(8'h80 | 8'(cp[11:6]));
            add_byte(8'h80 | 8'(cp[5:0]));
         end else if (kind < 85) begin
            add_byte(8'hF0 | 8'(cp[20:18]));
            add_byte(8'h80 | 8'(cp[17:12]));
            add_byte(8'h80 | 8'(cp[11:6]));
            add_byte(8'h80 | 8'(cp[5:0]));
         end else if (kind < 89) begin
            add_byte(8'h80 | 8'($urandom_range(0, 63)));
         end else if (kind < 92) begin
            add_byte(8'($urandom_range(8'hF8, 8'hFF)));
         end else if (kind < 97) begin
            // sequence cut short; whatever follows interrupts or restarts it
            len = $urandom_range(1, 3);
            lead = (len == 1) ? (8'hC0 | 8'(cp[4:0])) :
                   (len == 2) ? (8'hE0 | 8'(cp[3:0])) : (8'hF0 | 8'(cp[2:0]));
            add_byte(lead);
            keep = $urandom_range(0, len - 1);
            for (int k = 0; k < keep; k++)
               add_byte(8'h80 | 8'($urandom_range(0, 63)));
         end else begin
            add_byte(8'($urandom));
         end
      end
      string_bytes[string_bytes.size() - 1].end_of_string = 1'b1;
   endtask

   // stimulus
   initial begin
      int next_drain;
      req_type item;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[i]) begin
         cur_typed = directed_rows[i].typed;
         cur_count = directed_rows[i].count;
         cur_cp_first = directed_rows[i].cp_first;
         cur_cp_second = directed_rows[i].cp_second;
         send_item(directed_rows[i].data_byte, directed_rows[i].end_of_string);
      end
      cur_typed = 1'b0;
      drain();

      // random strings, with a long stretch of no idling in the middle
      next_drain = items_sent + DRAIN_EVERY;
      while (items_sent < RANDOM_ITEMS) begin
         build_string();
         while (string_bytes.size() != 0) begin
            item = string_bytes.pop_front();
            steady = (items_sent >= 600) && (items_sent < 850);
            send_item(item.data_byte, item.end_of_string);
         end
         if (items_sent >= next_drain) begin
            drain();
            next_drain = items_sent + DRAIN_EVERY;
         end
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      // wait for the last code points, then a short quiet tail
      while (expected_cps.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_cps.size() != 0) begin
         $error("%0d code points never delivered", expected_cps.size());
         errors++;
      end

      $display("run: %0d bytes in %0d strings, %0d code points checked",
               items_sent, strings_sent, cps_checked);
      $display("run: %0d bytes gave two code points, %0d mismatches",
               double_items, errors);
      if (errors == 0)
         $display("PASS utf8_stream_decoder");
      else
         $display("FAIL utf8_stream_decoder");
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/usd_pkg.sv
rtl/usd_decode.sv
rtl/usd_result_fifo.sv
rtl/utf8_stream_decoder.sv
rtl/usd_checker.sv
tb/utf8_stream_decoder_tb.sv
